// ----- src/psp_pkg.sv -----
`default_nettype none

package psp_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_POINTS = 8;
  localparam int DEF_COORD_BITS = 24;

  // Width of the point index fields on the result port.
  localparam int IDX_W = 3;

  // The similarity is a Q1.16 value; its square is scaled by 2^32 before division.
  localparam int SIM_W     = 17;
  localparam int SIM_SHIFT = 32;

  // The scaled quotient never exceeds 2^32, so 33 quotient bits suffice.
  localparam int QUO_W = SIM_SHIFT + 1;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_PAIRED = 2'd0;
  localparam status_t ST_SIZE   = 2'd1;
  localparam status_t ST_OVF    = 2'd2;
  localparam status_t ST_EMPTY  = 2'd3;

endpackage

`default_nettype wire

// ----- src/psp_mac.sv -----
`default_nettype none

// Shift-and-add multiply-accumulate: acc = acc_in + x * y, one multiplier bit
// per cycle. It finishes as soon as the remaining multiplier bits are zero.
module psp_mac #(
  parameter int W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [W-1:0]     x,
  input  wire logic [W-1:0]     y,
  input  wire logic [2*W-1:0]   acc_in,
  output logic                  busy,
  output logic [2*W-1:0]        acc
);

  logic [2*W-1:0] x_r;
  logic [W-1:0]   y_r;
  logic [2*W-1:0] acc_r;

  // Load operands on start, then add the shifted multiplicand for each set bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r <= '0;
    end else if (start) begin
      x_r   <= {{W{1'b0}}, x};
      y_r   <= y;
      acc_r <= acc_in;
    end else if (y_r != '0) begin
      if (y_r[0]) begin
        acc_r <= acc_r + x_r;
      end
      x_r <= {x_r[2*W-2:0], 1'b0};
      y_r <= {1'b0, y_r[W-1:1]};
    end
  end

  assign busy = (y_r != '0);
  assign acc  = acc_r;

endmodule

`default_nettype wire

// ----- src/psp_div.sv -----
`default_nettype none

// Restoring divider for num / den where the quotient is known to fit in
// QUO_W bits. One quotient bit per cycle.
module psp_div import psp_pkg::*; #(
  parameter int DNW = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [DNW+SIM_SHIFT-1:0]    num,
  input  wire logic [DNW-1:0]              den,
  output logic                             busy,
  output logic [QUO_W-1:0]                 quo
);

  localparam int NW  = DNW + SIM_SHIFT;
  localparam int CNW = $clog2(QUO_W + 1);

  logic [NW-1:0]    rem_r;
  logic [NW-1:0]    dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNW-1:0]   cnt_r;

  // Compare against the divisor shifted to the current quotient bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      rem_r <= num;
      dsh_r <= {den, {SIM_SHIFT{1'b0}}};
      quo_r <= '0;
      cnt_r <= CNW'(QUO_W);
    end else if (cnt_r != '0) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end
      dsh_r <= {1'b0, dsh_r[NW-1:1]};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ----- src/psp_isqrt.sv -----
`default_nettype none

// Digit-by-digit integer square root, floor(sqrt(v)), one root bit per cycle.
module psp_isqrt #(
  parameter int IW = 34
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [IW-1:0]     v,
  output logic                   busy,
  output logic [IW/2-1:0]        root
);

  localparam int RTW = IW / 2;
  localparam int RMW = RTW + 2;
  localparam int CNW = $clog2(RTW + 1);

  logic [IW-1:0]  v_r;
  logic [RMW-1:0] rem_r;
  logic [RTW-1:0] root_r;
  logic [CNW-1:0] cnt_r;
  logic [RMW+1:0] rem_sh;
  logic [RMW+1:0] trial;

  // Bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem_r, v_r[IW-1:IW-2]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      v_r    <= v;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNW'(RTW);
    end else if (cnt_r != '0) begin
      if (rem_sh >= trial) begin
        rem_r  <= RMW'(rem_sh - trial);
        root_r <= {root_r[RTW-2:0], 1'b1};
      end else begin
        rem_r  <= RMW'(rem_sh);
        root_r <= {root_r[RTW-2:0], 1'b0};
      end
      v_r   <= {v_r[IW-3:0], 2'b00};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy = (cnt_r != '0);
  assign root = root_r;

endmodule

`default_nettype wire

// ----- src/point_set_signature_pairing.sv -----
`default_nettype none

// Channel   Direction  Handshake                     Payload
// request   in         start high while busy low     in_req_type, in_px/py/pz, in_load_end
// result    out        out_valid, one cycle          out_status, indices, points, final_res
//
// A point without load_end is stored and busy stays low.
// A point with load_end that starts an evaluation keeps busy high for all of it; the
// shared multiply-accumulate, divide and square-root units set how long it lasts,
// and short operands finish sooner.
// A status result (sizes differ, overflow, empty) leaves in the cycle after the request.
// Reset is synchronous and active low; it clears the counts, the state and out_valid.
// Results cannot be stalled: each stands on the output ports for exactly one cycle.
module point_set_signature_pairing import psp_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_req_type,
  input  wire logic signed [COORD_BITS-1:0]  in_px,
  input  wire logic signed [COORD_BITS-1:0]  in_py,
  input  wire logic signed [COORD_BITS-1:0]  in_pz,
  input  wire logic                          in_load_end,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [IDX_W-1:0]                   out_a_index,
  output logic [IDX_W-1:0]                   out_b_index,
  output logic signed [COORD_BITS-1:0]       out_a_x,
  output logic signed [COORD_BITS-1:0]       out_a_y,
  output logic signed [COORD_BITS-1:0]       out_a_z,
  output logic signed [COORD_BITS-1:0]       out_b_x,
  output logic signed [COORD_BITS-1:0]       out_b_y,
  output logic signed [COORD_BITS-1:0]       out_b_z,
  output logic                               out_final_res
);

  localparam int C    = COORD_BITS;
  localparam int LOGM = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int DB   = C + 1;
  localparam int SQW  = 2 * C + 2;
  localparam int DW   = 2 * DB + LOGM;
  localparam int PW   = 2 * DW;
  localparam int IW   = (SQW > QUO_W + 1) ? SQW : QUO_W + 1;
  localparam int RTW  = IW / 2;
  localparam int PTW  = 3 * C;
  localparam int SAW  = 2 * LOGM;
  localparam int SDEP = 1 << SAW;
  localparam int ROWN = MAX_POINTS - 1;

  typedef enum logic [4:0] {
    S_IDLE, S_SG_RDI, S_SG_LDI, S_SG_RDJ, S_SG_MUL, S_SG_MW, S_SG_SQW, S_SG_WR,
    S_PR_I, S_PR_J, S_PR_RD, S_PR_M, S_PR_MW, S_PR_CHK, S_PR_DDW, S_PR_PW,
    S_PR_DW, S_PR_QW, S_PR_SEL, S_PR_ORD, S_PR_OUT
  } state_t;

  state_t state_r;

  // Load bookkeeping.
  logic [CW-1:0] cnt_a_r, cnt_b_r, cnt_a_nxt, cnt_b_nxt;
  logic          ovf_r, ovf_nxt, full;
  status_t       status_nxt;

  // Sequencer counters and working registers.
  logic [CW-1:0]    n_r, i_r, j_r, k_r, p_r, pick_r;
  logic [1:0]       c_r;
  logic             set_r;
  logic [PTW-1:0]   pi_r;
  logic [DB-1:0]    row_r [ROWN];
  logic [DB-1:0]    row_ins [ROWN];
  logic [ROWN-1:0]  lt;
  logic [DW-1:0]    dot_r, na_r, nb_r;
  logic [PW-1:0]    dd_r;
  logic [SIM_W-1:0] q_r, best_r;
  logic             qd_r;

  // Result registers.
  logic                  out_valid_r, out_final_r;
  status_t               out_status_r;
  logic [IDX_W-1:0]      out_a_index_r, out_b_index_r;
  logic signed [C-1:0]   out_a_x_r, out_a_y_r, out_a_z_r;
  logic signed [C-1:0]   out_b_x_r, out_b_y_r, out_b_z_r;

  // Memories.
  logic [PTW-1:0] pa_mem [MAX_POINTS];
  logic [PTW-1:0] pb_mem [MAX_POINTS];
  logic [PTW-1:0] pa_rd_r, pb_rd_r, pt_rd;
  logic [LOGM-1:0] pa_addr, pb_addr;
  logic [DB-1:0]  sa_mem [SDEP];
  logic [DB-1:0]  sb_mem [SDEP];
  logic [DB-1:0]  sa_rd_r, sb_rd_r;
  logic [SAW-1:0] sa_addr, sb_addr;
  logic           sig_we;

  // Shared units.
  logic             mac_start, mac_busy;
  logic [DW-1:0]    mac_x, mac_y;
  logic [PW-1:0]    mac_acc_in, mac_acc;
  logic             div_start, div_busy;
  logic [QUO_W-1:0] div_quo;
  logic             sq_start, sq_busy;
  logic [IW-1:0]    sq_in;
  logic [RTW-1:0]   sq_root;

  // Coordinate difference for the distance.
  logic [C-1:0] ca, cb, absd;
  logic [C:0]   dif, dif_neg;

  // Accept-time counts, overflow and status.
  always_comb begin
    full      = in_req_type ? (cnt_b_r >= CW'(MAX_POINTS)) : (cnt_a_r >= CW'(MAX_POINTS));
    cnt_a_nxt = (!in_req_type && !full) ? cnt_a_r + 1'b1 : cnt_a_r;
    cnt_b_nxt = (in_req_type && !full) ? cnt_b_r + 1'b1 : cnt_b_r;
    ovf_nxt   = ovf_r | full;
    if (ovf_nxt) begin
      status_nxt = ST_OVF;
    end else if (cnt_a_nxt != cnt_b_nxt) begin
      status_nxt = ST_SIZE;
    end else if (cnt_a_nxt == '0) begin
      status_nxt = ST_EMPTY;
    end else begin
      status_nxt = ST_PAIRED;
    end
  end

  // Point stores: written on accept, one registered read port each.
  always_comb begin
    if (state_r == S_PR_ORD || state_r == S_PR_OUT) begin
      pa_addr = i_r[LOGM-1:0];
      pb_addr = pick_r[LOGM-1:0];
    end else if (state_r == S_SG_RDI) begin
      pa_addr = i_r[LOGM-1:0];
      pb_addr = i_r[LOGM-1:0];
    end else begin
      pa_addr = j_r[LOGM-1:0];
      pb_addr = j_r[LOGM-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start && !full && !in_req_type) begin
      pa_mem[cnt_a_r[LOGM-1:0]] <= {in_px, in_py, in_pz};
    end
    pa_rd_r <= pa_mem[pa_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start && !full && in_req_type) begin
      pb_mem[cnt_b_r[LOGM-1:0]] <= {in_px, in_py, in_pz};
    end
    pb_rd_r <= pb_mem[pb_addr];
  end

  assign pt_rd = set_r ? pb_rd_r : pa_rd_r;

  // Signature stores, addressed by point and rank.
  assign sig_we  = (state_r == S_SG_WR);
  assign sa_addr = {i_r[LOGM-1:0], p_r[LOGM-1:0]};
  assign sb_addr = sig_we ? {i_r[LOGM-1:0], p_r[LOGM-1:0]} : {j_r[LOGM-1:0], p_r[LOGM-1:0]};

  always_ff @(posedge clk) begin
    if (sig_we && !set_r) begin
      sa_mem[sa_addr] <= row_r[0];
    end
    sa_rd_r <= sa_mem[sa_addr];
  end

  always_ff @(posedge clk) begin
    if (sig_we && set_r) begin
      sb_mem[sb_addr] <= row_r[0];
    end
    sb_rd_r <= sb_mem[sb_addr];
  end

  // Absolute difference of the selected coordinate.
  always_comb begin
    case (c_r)
      2'd0: begin
        ca = pi_r[PTW-1 -: C];
        cb = pt_rd[PTW-1 -: C];
      end
      2'd1: begin
        ca = pi_r[2*C-1 -: C];
        cb = pt_rd[2*C-1 -: C];
      end
      default: begin
        ca = pi_r[C-1:0];
        cb = pt_rd[C-1:0];
      end
    endcase
    dif     = {ca[C-1], ca} - {cb[C-1], cb};
    dif_neg = ~dif + 1'b1;
    absd    = dif[C] ? dif_neg[C-1:0] : dif[C-1:0];
  end

  // Sorted insertion of a new distance into the row (descending order).
  always_comb begin
    for (int p = 0; p < ROWN; p++) begin
      lt[p] = (CW'(p) < k_r) && (row_r[p] < sq_root[DB-1:0]);
    end
    row_ins[0] = (lt[0] || k_r == '0) ? sq_root[DB-1:0] : row_r[0];
    for (int p = 1; p < ROWN; p++) begin
      if (lt[p-1]) begin
        row_ins[p] = row_r[p-1];
      end else if (lt[p] || CW'(p) == k_r) begin
        row_ins[p] = sq_root[DB-1:0];
      end else begin
        row_ins[p] = row_r[p];
      end
    end
  end

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    mac_start  = 1'b0;
    mac_x      = DW'(absd);
    mac_y      = DW'(absd);
    mac_acc_in = '0;
    case (state_r)
      S_SG_MUL: begin
        mac_start  = 1'b1;
        mac_acc_in = (c_r == 2'd0) ? '0 : mac_acc;
      end
      S_PR_M: begin
        mac_start = 1'b1;
        case (c_r)
          2'd0: begin
            mac_x      = DW'(sa_rd_r);
            mac_y      = DW'(sb_rd_r);
            mac_acc_in = PW'(dot_r);
          end
          2'd1: begin
            mac_x      = DW'(sa_rd_r);
            mac_y      = DW'(sa_rd_r);
            mac_acc_in = PW'(na_r);
          end
          default: begin
            mac_x      = DW'(sb_rd_r);
            mac_y      = DW'(sb_rd_r);
            mac_acc_in = PW'(nb_r);
          end
        endcase
      end
      S_PR_CHK: begin
        mac_start = (na_r != '0) && (nb_r != '0);
        mac_x     = dot_r;
        mac_y     = dot_r;
      end
      S_PR_DDW: begin
        mac_start = !mac_busy;
        mac_x     = na_r;
        mac_y     = nb_r;
      end
      default: begin
        mac_start = 1'b0;
      end
    endcase
  end

  assign div_start = (state_r == S_PR_PW) && !mac_busy;
  assign sq_start  = ((state_r == S_SG_MW) && !mac_busy && c_r == 2'd2) ||
                     ((state_r == S_PR_DW) && !div_busy);
  assign sq_in     = (state_r == S_PR_DW) ? IW'(div_quo) : mac_acc[IW-1:0];

  psp_mac #(.W(DW)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mac_start),
    .x      (mac_x),
    .y      (mac_y),
    .acc_in (mac_acc_in),
    .busy   (mac_busy),
    .acc    (mac_acc)
  );

  psp_div #(.DNW(PW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({dd_r, {SIM_SHIFT{1'b0}}}),
    .den   (mac_acc),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  psp_isqrt #(.IW(IW)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .v     (sq_in),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  // Sequencer: load, signature build for both sets, then pairing per set-A point.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_load_end) begin
              cnt_a_r <= '0;
              cnt_b_r <= '0;
              ovf_r   <= 1'b0;
              n_r     <= cnt_a_nxt;
              set_r   <= 1'b0;
              i_r     <= '0;
              if (status_nxt != ST_PAIRED) begin
                out_valid_r   <= 1'b1;
                out_status_r  <= status_nxt;
                out_a_index_r <= '0;
                out_b_index_r <= '0;
                out_a_x_r     <= '0;
                out_a_y_r     <= '0;
                out_a_z_r     <= '0;
                out_b_x_r     <= '0;
                out_b_y_r     <= '0;
                out_b_z_r     <= '0;
                out_final_r   <= 1'b1;
              end else begin
                state_r <= S_SG_RDI;
              end
            end else begin
              cnt_a_r <= cnt_a_nxt;
              cnt_b_r <= cnt_b_nxt;
              ovf_r   <= ovf_nxt;
            end
          end
        end
        S_SG_RDI: begin
          state_r <= S_SG_LDI;
        end
        S_SG_LDI: begin
          pi_r    <= pt_rd;
          j_r     <= '0;
          k_r     <= '0;
          state_r <= S_SG_RDJ;
        end
        S_SG_RDJ: begin
          if (j_r == n_r) begin
            p_r     <= '0;
            state_r <= S_SG_WR;
          end else if (j_r == i_r) begin
            j_r <= j_r + 1'b1;
          end else begin
            c_r     <= 2'd0;
            state_r <= S_SG_MUL;
          end
        end
        S_SG_MUL: begin
          state_r <= S_SG_MW;
        end
        S_SG_MW: begin
          if (!mac_busy) begin
            if (c_r == 2'd2) begin
              state_r <= S_SG_SQW;
            end else begin
              c_r     <= c_r + 1'b1;
              state_r <= S_SG_MUL;
            end
          end
        end
        S_SG_SQW: begin
          if (!sq_busy) begin
            row_r   <= row_ins;
            k_r     <= k_r + 1'b1;
            j_r     <= j_r + 1'b1;
            state_r <= S_SG_RDJ;
          end
        end
        S_SG_WR: begin
          // Shift the row out one rank per cycle.
          for (int p = 0; p < ROWN - 1; p++) begin
            row_r[p] <= row_r[p+1];
          end
          p_r <= p_r + 1'b1;
          if ({1'b0, p_r} + 2'd2 >= {1'b0, n_r}) begin
            if (i_r + 1'b1 == n_r) begin
              i_r <= '0;
              if (!set_r) begin
                set_r   <= 1'b1;
                state_r <= S_SG_RDI;
              end else begin
                state_r <= S_PR_I;
              end
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_SG_RDI;
            end
          end
        end
        S_PR_I: begin
          j_r     <= '0;
          state_r <= S_PR_J;
        end
        S_PR_J: begin
          dot_r   <= '0;
          na_r    <= '0;
          nb_r    <= '0;
          p_r     <= '0;
          c_r     <= 2'd0;
          state_r <= (n_r == CW'(1)) ? S_PR_CHK : S_PR_RD;
        end
        S_PR_RD: begin
          state_r <= S_PR_M;
        end
        S_PR_M: begin
          state_r <= S_PR_MW;
        end
        S_PR_MW: begin
          if (!mac_busy) begin
            case (c_r)
              2'd0:    dot_r <= mac_acc[DW-1:0];
              2'd1:    na_r  <= mac_acc[DW-1:0];
              default: nb_r  <= mac_acc[DW-1:0];
            endcase
            if (c_r == 2'd2) begin
              c_r <= 2'd0;
              p_r <= p_r + 1'b1;
              if ({1'b0, p_r} + 2'd2 >= {1'b0, n_r}) begin
                state_r <= S_PR_CHK;
              end else begin
                state_r <= S_PR_RD;
              end
            end else begin
              c_r     <= c_r + 1'b1;
              state_r <= S_PR_M;
            end
          end
        end
        S_PR_CHK: begin
          // A zero norm leaves the similarity undefined.
          if (na_r == '0 || nb_r == '0) begin
            qd_r    <= 1'b0;
            state_r <= S_PR_SEL;
          end else begin
            state_r <= S_PR_DDW;
          end
        end
        S_PR_DDW: begin
          if (!mac_busy) begin
            dd_r    <= mac_acc;
            state_r <= S_PR_PW;
          end
        end
        S_PR_PW: begin
          if (!mac_busy) begin
            state_r <= S_PR_DW;
          end
        end
        S_PR_DW: begin
          if (!div_busy) begin
            state_r <= S_PR_QW;
          end
        end
        S_PR_QW: begin
          if (!sq_busy) begin
            q_r     <= sq_root[SIM_W-1:0];
            qd_r    <= 1'b1;
            state_r <= S_PR_SEL;
          end
        end
        S_PR_SEL: begin
          // Candidate 0 sets the reference; later ones win only when strictly higher.
          if (j_r == '0) begin
            pick_r <= '0;
            best_r <= q_r;
          end else if (qd_r && q_r > best_r) begin
            best_r <= q_r;
            pick_r <= j_r;
          end
          if ((j_r == '0 && !qd_r) || j_r + 1'b1 == n_r) begin
            state_r <= S_PR_ORD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_PR_J;
          end
        end
        S_PR_ORD: begin
          state_r <= S_PR_OUT;
        end
        S_PR_OUT: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= ST_PAIRED;
          out_a_index_r <= IDX_W'(i_r);
          out_b_index_r <= IDX_W'(pick_r);
          out_a_x_r     <= pa_rd_r[PTW-1 -: C];
          out_a_y_r     <= pa_rd_r[2*C-1 -: C];
          out_a_z_r     <= pa_rd_r[C-1:0];
          out_b_x_r     <= pb_rd_r[PTW-1 -: C];
          out_b_y_r     <= pb_rd_r[2*C-1 -: C];
          out_b_z_r     <= pb_rd_r[C-1:0];
          out_final_r   <= (i_r + 1'b1 == n_r);
          if (i_r + 1'b1 == n_r) begin
            state_r <= S_IDLE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_PR_I;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_a_index   = out_a_index_r;
  assign out_b_index   = out_b_index_r;
  assign out_a_x       = out_a_x_r;
  assign out_a_y       = out_a_y_r;
  assign out_a_z       = out_a_z_r;
  assign out_b_x       = out_b_x_r;
  assign out_b_y       = out_b_y_r;
  assign out_b_z       = out_b_z_r;
  assign out_final_res = out_final_r;

`ifndef SYNTH
  // A status result is always the only, and therefore last, result.
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_PAIRED |-> out_final_res)
    else $error("status result without final_res");

  // The shared multiplier is never restarted while it is still working.
  a_mac_free: assert property (@(posedge clk) disable iff (!rst_n)
    mac_start |-> !mac_busy)
    else $error("multiply-accumulate started while busy");

  // The last pair of an evaluation returns the block to idle.
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |-> !busy)
    else $error("final result while still busy");

  // A request that ends the load starts the next load from empty counts.
  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_load_end |=> cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r)
    else $error("load state not cleared after evaluation");
`endif

endmodule

`default_nettype wire
